// File: sv/assert_macros.svh
// Assertion macros used by the checker file.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Implication also checked during reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);
`endif

// File: sv/fpalu_pkg.sv
// Package for the fixed-point ALU: opcodes, widths and defaults.
// Depends on nothing.
`default_nettype none
package fpalu_pkg;
	localparam int DATA_W = 32;
	localparam int OP_W = 4;
	localparam int FRAC_BITS_DEF = 8;
	localparam logic [OP_W-1:0] OP_ADD = 4'd0;
	localparam logic [OP_W-1:0] OP_SUB = 4'd1;
	localparam logic [OP_W-1:0] OP_MUL = 4'd2;
	localparam logic [OP_W-1:0] OP_DIV = 4'd3;
	localparam logic [OP_W-1:0] OP_MIN = 4'd4;
	localparam logic [OP_W-1:0] OP_MAX = 4'd5;
	localparam logic [OP_W-1:0] OP_INC = 4'd6;
	localparam logic [OP_W-1:0] OP_DEC = 4'd7;
	localparam logic [OP_W-1:0] OP_TOINT = 4'd8;
	localparam logic [OP_W-1:0] OP_FROMINT = 4'd9;
endpackage
`default_nettype wire

// File: sv/fpalu_div.sv
// Pipelined restoring divider on magnitudes, one quotient bit per stage.
// Depends on fpalu_pkg; fed by fixed_point_alu_top.
`default_nettype none
module fpalu_div import fpalu_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF,
	parameter int NUM_W = DATA_W + FRAC_BITS
) (
	input wire logic clk,
	input wire logic adv,
	input wire logic [NUM_W-1:0] num,
	input wire logic [DATA_W-1:0] den,
	output logic [NUM_W-1:0] quo
);
	// per stage: partial remainder, remaining numerator bits, divisor
	logic [DATA_W-1:0] rem_q [1:NUM_W-1];
	logic [NUM_W-1:0] nb_q [1:NUM_W];
	logic [DATA_W-1:0] dv_q [1:NUM_W-1];

	for (genvar i = 0; i < NUM_W; i++) begin : g_st
		logic [DATA_W-1:0] rem_in;
		logic [NUM_W-1:0] nb_in;
		logic [DATA_W-1:0] dv_in;
		logic [DATA_W:0] sh;
		logic [DATA_W:0] df;
		if (i == 0) begin : g_first
			assign rem_in = '0;
			assign nb_in = num;
			assign dv_in = den;
		end else begin : g_next
			assign rem_in = rem_q[i];
			assign nb_in = nb_q[i];
			assign dv_in = dv_q[i];
		end
		assign sh = {rem_in, nb_in[NUM_W-1]};
		assign df = sh - {1'b0, dv_in};
		always_ff @(posedge clk) begin
			if (adv) nb_q[i+1] <= {nb_in[NUM_W-2:0], ~df[DATA_W]};
		end
		// the last stage keeps only the quotient
		if (i < NUM_W-1) begin : g_carry
			always_ff @(posedge clk) begin
				if (adv) begin
					rem_q[i+1] <= df[DATA_W] ? sh[DATA_W-1:0] : df[DATA_W-1:0];
					dv_q[i+1] <= dv_in;
				end
			end
		end
	end

	assign quo = nb_q[NUM_W];
endmodule
`default_nettype wire

// File: sv/fixed_point_alu_top.sv
// Fixed-point ALU, 32-bit raw values with FRAC_BITS fractional bits.
// Every opcode has the same latency; one request per cycle unless the output stalls.
// Uses fpalu_pkg and fpalu_div.
//
// One request enters per cycle and every opcode takes the same number of
// cycles: two front stages (operand capture, then sign, magnitude and the
// product), then 32+FRAC_BITS divider stages, one quotient bit each, then
// the output register. The divider depth sets the latency; throughput is one
// request per cycle. The whole pipeline advances when the output register is
// empty or being taken, so a stall holds every stage and drops nothing.
`default_nettype none
module fixed_point_alu_top import fpalu_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	input wire logic [OP_W-1:0] op,
	input wire logic signed [DATA_W-1:0] operand_a,
	input wire logic signed [DATA_W-1:0] operand_b,
	output logic out_valid,
	input wire logic out_stall,
	output logic signed [DATA_W-1:0] result_value,
	output logic a_less,
	output logic a_equal,
	output logic a_greater,
	output logic divide_by_zero
);
	localparam int NUM_W = DATA_W + FRAC_BITS;
	localparam int LAT = NUM_W + 1; // stages between s1 and the output

	logic adv;
	assign adv = !out_valid || !out_stall;
	assign in_stall = !adv;

	// stage 1: capture request
	logic v_s1;
	logic [OP_W-1:0] op_s1;
	logic signed [DATA_W-1:0] a_s1, b_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (adv) v_s1 <= in_valid;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			op_s1 <= op;
			a_s1 <= operand_a;
			b_s1 <= operand_b;
		end
	end

	// stage 2: compare, simple ops, product, divider operands
	logic lt, eq, gt;
	logic signed [2*DATA_W-1:0] prod;
	logic [DATA_W-1:0] simple;
	logic [DATA_W-1:0] mag_a, mag_b;
	assign lt = a_s1 < b_s1;
	assign eq = a_s1 == b_s1;
	assign gt = a_s1 > b_s1;
	assign prod = a_s1 * b_s1;
	assign mag_a = a_s1[DATA_W-1] ? DATA_W'(-a_s1) : a_s1;
	assign mag_b = b_s1[DATA_W-1] ? DATA_W'(-b_s1) : b_s1;
	always_comb begin
		case (op_s1)
			OP_ADD: simple = a_s1 + b_s1;
			OP_SUB: simple = a_s1 - b_s1;
			OP_MUL: simple = DATA_W'(prod >>> FRAC_BITS);
			OP_MIN: simple = lt ? a_s1 : b_s1;
			OP_MAX: simple = gt ? a_s1 : b_s1;
			OP_INC: simple = a_s1 + DATA_W'(1);
			OP_DEC: simple = a_s1 - DATA_W'(1);
			OP_TOINT: simple = DATA_W'(a_s1 >>> FRAC_BITS);
			OP_FROMINT: simple = DATA_W'(a_s1 << FRAC_BITS);
			default: simple = '0;
		endcase
	end

	typedef struct packed {
		logic [DATA_W-1:0] simple;
		logic is_div;
		logic dz;
		logic neg;
		logic lt;
		logic eq;
		logic gt;
	} side_t;

	side_t side_d;
	assign side_d = '{simple: simple, is_div: op_s1 == OP_DIV,
		dz: (op_s1 == OP_DIV) && (b_s1 == '0),
		neg: a_s1[DATA_W-1] ^ b_s1[DATA_W-1], lt: lt, eq: eq, gt: gt};

	// side data and valid delay line matching the divider
	side_t side_q [LAT];
	logic [LAT-1:0] v_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_q <= '0;
		else if (adv) v_q <= {v_q[LAT-2:0], v_s1};
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			side_q[0] <= side_d;
			for (int i = 1; i < LAT; i++) side_q[i] <= side_q[i-1];
		end
	end

	// divider input registered as stage 2 inside the divider chain
	logic [NUM_W-1:0] num_s2;
	logic [DATA_W-1:0] den_s2;
	always_ff @(posedge clk) begin
		if (adv) begin
			num_s2 <= NUM_W'(mag_a) << FRAC_BITS;
			den_s2 <= mag_b;
		end
	end

	logic [NUM_W-1:0] quo;
	fpalu_div #(.FRAC_BITS(FRAC_BITS), .NUM_W(NUM_W)) u_div (
		.clk(clk), .adv(adv),
		.num(num_s2), .den(den_s2), .quo(quo)
	);

	// final: sign-fix quotient, pick result, register output
	side_t sf;
	logic [DATA_W-1:0] qv;
	assign sf = side_q[LAT-1];
	assign qv = sf.neg ? DATA_W'(-quo) : quo[DATA_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (adv) out_valid <= v_q[LAT-1];
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			result_value <= !sf.is_div ? sf.simple : (sf.dz ? '0 : qv);
			a_less <= sf.lt;
			a_equal <= sf.eq;
			a_greater <= sf.gt;
			divide_by_zero <= sf.dz;
		end
	end
endmodule
`default_nettype wire

// File: sv/fpalu_checker.sv
// Port-level checker for the fixed-point ALU, bound to the top level.
// Depends on fpalu_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module fpalu_checker import fpalu_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_stall,
	input wire logic out_valid,
	input wire logic out_stall,
	input wire logic signed [DATA_W-1:0] result_value,
	input wire logic a_less,
	input wire logic a_equal,
	input wire logic a_greater,
	input wire logic divide_by_zero
);
	`ASSERT_CLK(a_onecmp, clk, arst_n, out_valid |-> $onehot({a_less, a_equal, a_greater}), "compare flags not one-hot")
	`ASSERT_CLK(a_dzres, clk, arst_n, (out_valid && divide_by_zero) |-> (result_value == '0), "divide by zero result not zero")
	`ASSERT_CLK(a_stall, clk, arst_n, (out_valid && out_stall) |-> in_stall, "input taken while output held")
	`ASSERT_CLK(a_hold, clk, arst_n, (out_valid && out_stall) |=> (out_valid && $stable(result_value)), "held result changed")
	`ASSERT_ALWAYS(a_rst, clk, !arst_n |-> !out_valid, "output valid in reset")
endmodule

bind fixed_point_alu_top fpalu_checker u_chk (.*);
`default_nettype wire
